/* hw/rtl/sst_pkg.sv */
// ============================================================================
// sst_pkg
// Shared types and codes of the stream statistics table.
// ============================================================================
`default_nettype none

package sst_pkg;

    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_EXISTING = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_READ_OK  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_IDLE     = 3'd6;

    typedef struct packed {
        logic signed [31:0] stream_id;
        logic [31:0]        frame_type;
        logic [63:0]        start_time;
        logic [63:0]        end_time;
        logic [31:0]        frame_count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] slot;
        logic [7:0] count;
        t_entry     entry;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/sst_req_if.sv */
// ============================================================================
// sst_req_if
// Request channel: frame header record, entry read or table clear.
// ============================================================================
`default_nettype none

interface sst_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] stream_id;
    logic [31:0]        frame_type;
    logic [63:0]        frame_time;
    logic [6:0]         read_index;

    modport source (
        output valid, req_type, stream_id, frame_type, frame_time, read_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, stream_id, frame_type, frame_time, read_index,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/sst_res_if.sv */
// ============================================================================
// sst_res_if
// Result channel: status and entry contents of one request.
// ============================================================================
`default_nettype none

interface sst_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [6:0]         entry_slot;
    logic [7:0]         entry_count;
    logic signed [31:0] out_stream_id;
    logic [31:0]        out_frame_type;
    logic [63:0]        out_start_time;
    logic [63:0]        out_end_time;
    logic [31:0]        out_frame_count;

    modport source (
        output valid, status, entry_slot, entry_count, out_stream_id,
               out_frame_type, out_start_time, out_end_time, out_frame_count,
        input  ready
    );
    modport sink (
        input  valid, status, entry_slot, entry_count, out_stream_id,
               out_frame_type, out_start_time, out_end_time, out_frame_count,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/stream_statistics_table_unit.sv */
// ============================================================================
// stream_statistics_table_unit
// Per-stream statistics table fed with frame headers, with entry read and
// table clear requests. Entries live in one RAM searched linearly by id.
// ============================================================================
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ------------------------------------------
//  i_req    in   valid/ready          req_type, stream_id, frame_type,
//                                     frame_time, read_index
//  o_res    out  valid/ready          status, entry_slot, entry_count, entry
//
//  Record: up to one RAM read per stored entry, pipelined against the id compare,
//  stopping at the first matching id.
//  One request in flight at a time.
//  Reset empties the table and clears the halt flag; no RAM sweep.
//  A result waits in the output register while the next request is taken.
// ============================================================================
`default_nettype none

module stream_statistics_table_unit #(
    parameter int MAX_ENTRIES = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sst_req_if.sink   i_req,
    sst_res_if.source o_res
);
    import sst_pkg::*;

    localparam int SW = $clog2(MAX_ENTRIES);

    logic          eng_valid;
    logic          eng_ready;
    t_result       eng_res;
    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [SW-1:0] ram_raddr;
    t_entry        ram_rdata;

    logic          r_out_valid, n_out_valid;
    t_result       r_out;
    logic          load;

    sst_engine #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (eng_valid),
        .i_res_ready (eng_ready),
        .o_res       (eng_res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    sst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign eng_ready = !r_out_valid || o_res.ready;
    assign load      = eng_valid && eng_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= eng_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out.status;
    assign o_res.entry_slot      = r_out.slot;
    assign o_res.entry_count     = r_out.count;
    assign o_res.out_stream_id   = r_out.entry.stream_id;
    assign o_res.out_frame_type  = r_out.entry.frame_type;
    assign o_res.out_start_time  = r_out.entry.start_time;
    assign o_res.out_end_time    = r_out.entry.end_time;
    assign o_res.out_frame_count = r_out.entry.frame_count;

endmodule

`default_nettype wire

/* hw/rtl/sst_ram.sv */
// ============================================================================
// sst_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/sst_engine.sv */
// ============================================================================
// sst_engine
// Request sequencer: linear id search, read-modify-write of the entry RAM,
// entry reads and table clear.
// ============================================================================
`default_nettype none

module sst_engine #(
    parameter int MAX_ENTRIES = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    sst_req_if.sink                             i_req,
    output logic                                o_res_valid,
    input  wire logic                           i_res_ready,
    output sst_pkg::t_result                    o_res,
    output logic                                o_ram_we,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_ram_waddr,
    output sst_pkg::t_entry                     o_ram_wdata,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_ram_raddr,
    input  wire sst_pkg::t_entry                i_ram_rdata
);
    import sst_pkg::*;

    localparam int SW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_SEARCH   = 5'b00100,
        S_READ     = 5'b01000,
        S_EMIT     = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_used, n_used;
    logic               r_halted, n_halted;
    logic [CW-1:0]      r_issue, n_issue;
    logic               r_cmp_valid, n_cmp_valid;
    logic [SW-1:0]      r_cmp_idx, n_cmp_idx;
    t_result            r_res, n_res;

    logic [1:0]         r_req_type;
    logic signed [31:0] r_id;
    logic [31:0]        r_ftype;
    logic [63:0]        r_ftime;
    logic [6:0]         r_idx;

    logic               accept;
    logic               issuing;
    logic               hit;
    logic               rd_ok;
    logic [CMP_W-1:0]   idx_w;
    logic [CMP_W-1:0]   used_w;
    t_entry             upd_entry;
    t_entry             new_entry;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign issuing = (r_issue < r_used);
    assign hit     = r_cmp_valid && (i_ram_rdata.stream_id == r_id);
    assign idx_w   = CMP_W'(r_idx);
    assign used_w  = CMP_W'(r_used);
    assign rd_ok   = (idx_w < used_w);

    always_comb begin
        upd_entry          = i_ram_rdata;
        upd_entry.end_time = r_ftime;
        if (i_ram_rdata.frame_count != '1) begin
            upd_entry.frame_count = i_ram_rdata.frame_count + 32'd1;
        end
        new_entry.stream_id   = r_id;
        new_entry.frame_type  = r_ftype;
        new_entry.start_time  = r_ftime;
        new_entry.end_time    = r_ftime;
        new_entry.frame_count = 32'd1;
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_halted    = r_halted;
        n_issue     = r_issue;
        n_cmp_valid = 1'b0;
        n_cmp_idx   = r_issue[SW-1:0];
        n_res       = r_res;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_cmp_idx;
        o_ram_wdata = upd_entry;
        o_ram_raddr = r_issue[SW-1:0];
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res.status = ST_IDLE;
                n_res.slot   = '0;
                n_res.entry  = '0;
                n_state      = S_EMIT;
                case (r_req_type)
                    REQ_RECORD: begin
                        if (!r_halted) begin
                            n_issue = '0;
                            n_state = S_SEARCH;
                        end
                    end
                    REQ_READ: begin
                        n_res.slot = r_idx;
                        if (rd_ok) begin
                            o_ram_raddr = idx_w[SW-1:0];
                            n_state     = S_READ;
                        end else begin
                            n_res.status = ST_EMPTY;
                        end
                    end
                    REQ_CLEAR: begin
                        n_used   = '0;
                        n_halted = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            S_SEARCH: begin
                if (issuing) begin
                    n_issue = r_issue + CW'(1);
                end
                n_cmp_valid = issuing;
                if (hit) begin
                    o_ram_we     = 1'b1;
                    n_res.status = (i_ram_rdata.frame_type != r_ftype) ? ST_MISMATCH
                                                                       : ST_EXISTING;
                    n_res.slot   = 7'(r_cmp_idx);
                    n_res.entry  = upd_entry;
                    n_state      = S_EMIT;
                end else if (!issuing && !r_cmp_valid) begin
                    if (r_used == MAX_CNT) begin
                        n_halted     = 1'b1;
                        n_res.status = ST_FULL;
                    end else begin
                        o_ram_we     = 1'b1;
                        o_ram_waddr  = r_used[SW-1:0];
                        o_ram_wdata  = new_entry;
                        n_used       = r_used + CW'(1);
                        n_res.status = ST_NEW;
                        n_res.slot   = 7'(r_used);
                        n_res.entry  = new_entry;
                    end
                    n_state = S_EMIT;
                end
            end
            S_READ: begin
                n_res.status = ST_READ_OK;
                n_res.entry  = i_ram_rdata;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res       = r_res;
        o_res.count = 8'(r_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_halted    <= 1'b0;
            r_issue     <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_halted    <= n_halted;
            r_issue     <= n_issue;
            r_cmp_valid <= n_cmp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
        if (accept) begin
            r_req_type <= i_req.req_type;
            r_id       <= i_req.stream_id;
            r_ftype    <= i_req.frame_type;
            r_ftime    <= i_req.frame_time;
            r_idx      <= i_req.read_index;
        end
    end

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= MAX_CNT)
        else $error("entry count above table size");

    a_halt_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_used == MAX_CNT))
        else $error("table halted while not full");

    a_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == S_SEARCH))
        else $error("entry write outside search");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && !hit) |=> (r_used == $past(r_used) + CW'(1)))
        else $error("insert did not advance entry count");

endmodule

`default_nettype wire

/* tb/sst_stats_checker.sv */
// ============================================================================
// sst_stats_checker
// Watches the request and result channels of the stream statistics table.
// Keeps its own copy of the table, predicts the result of every accepted
// request and compares it field by field with the next accepted result.
// ============================================================================
`default_nettype none

module sst_stats_checker #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sst_req_if        i_req,
    sst_res_if        i_res,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    t_entry  stream_rows [TABLE_DEPTH];
    int      used_slots;
    bit      table_halted;
    t_result expected_q [$];
    t_result want;

    function automatic t_result table_outcome(
        input logic [1:0]         kind,
        input logic signed [31:0] sid,
        input logic [31:0]        ftype,
        input logic [63:0]        ftime,
        input logic [6:0]         idx
    );
        t_result r;
        int      slot;
        r = '0;
        case (kind)
            REQ_RECORD: begin
                if (table_halted) begin
                    r.status = ST_IDLE;
                end else begin
                    slot = 0;
                    while (slot < used_slots && stream_rows[slot].stream_id != sid)
                        slot++;
                    if (slot < used_slots) begin
                        r.status = (stream_rows[slot].frame_type != ftype) ?
                                   ST_MISMATCH : ST_EXISTING;
                    end else if (used_slots >= TABLE_DEPTH) begin
                        table_halted = 1'b1;
                        r.status     = ST_FULL;
                        slot         = -1;
                    end else begin
                        slot = used_slots;
                        used_slots++;
                        stream_rows[slot].stream_id   = sid;
                        stream_rows[slot].frame_type  = ftype;
                        stream_rows[slot].start_time  = ftime;
                        stream_rows[slot].frame_count = '0;
                        r.status = ST_NEW;
                    end
                    if (slot >= 0) begin
                        stream_rows[slot].end_time = ftime;
                        if (stream_rows[slot].frame_count != 32'hFFFF_FFFF)
                            stream_rows[slot].frame_count++;
                        r.slot  = slot[6:0];
                        r.entry = stream_rows[slot];
                    end
                end
            end
            REQ_READ: begin
                r.slot = idx;
                if (idx < used_slots && idx < TABLE_DEPTH) begin
                    r.status = ST_READ_OK;
                    r.entry  = stream_rows[idx];
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            REQ_CLEAR: begin
                used_slots   = 0;
                table_halted = 1'b0;
                r.status     = ST_IDLE;
            end
            default: begin
                r.status = ST_IDLE;
            end
        endcase
        r.count = used_slots[7:0];
        return r;
    endfunction

    function automatic void check_field(
        input string       name,
        input logic [63:0] want_v,
        input logic [63:0] got_v
    );
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            used_slots   = 0;
            table_halted = 1'b0;
            expected_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with no request outstanding, status %0d",
                           i_res.status);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", 64'(want.status), 64'(i_res.status));
                    check_field("entry_slot", 64'(want.slot), 64'(i_res.entry_slot));
                    check_field("entry_count", 64'(want.count), 64'(i_res.entry_count));
                    check_field("out_stream_id", 64'($unsigned(want.entry.stream_id)),
                                64'($unsigned(i_res.out_stream_id)));
                    check_field("out_frame_type", 64'(want.entry.frame_type),
                                64'(i_res.out_frame_type));
                    check_field("out_start_time", want.entry.start_time,
                                i_res.out_start_time);
                    check_field("out_end_time", want.entry.end_time, i_res.out_end_time);
                    check_field("out_frame_count", 64'(want.entry.frame_count),
                                64'(i_res.out_frame_count));
                end
            end
            if (i_req.valid && i_req.ready)
                expected_q.push_back(table_outcome(i_req.req_type, i_req.stream_id,
                                                   i_req.frame_type, i_req.frame_time,
                                                   i_req.read_index));
        end
        o_pending = expected_q.size();
    end

endmodule

`default_nettype wire

/* tb/stream_statistics_table_unit_tb.sv */
// ============================================================================
// stream_statistics_table_unit_tb
// Drives record, read, clear and unused requests into the stream statistics
// table: a directed opening, then mixed traffic over a small pool of streams
// and runs that fill the table until it halts, under changing backpressure.
// ============================================================================
`default_nettype none

module stream_statistics_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int         TABLE_DEPTH = 128;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         DRAIN_HOLD  = TABLE_DEPTH + 8;
    localparam int         POOL_SIZE   = 8;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   cycle_count = 0;
    int   checker_fails;
    int   outstanding;

    logic signed [31:0] id_pool   [POOL_SIZE];
    logic [31:0]        type_pool [POOL_SIZE];

    sst_req_if req_ch ();
    sst_res_if res_ch ();

    stream_statistics_table_unit #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    sst_stats_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) stats_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (checker_fails),
        .o_pending    (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_request(
        input logic [1:0]         kind,
        input logic signed [31:0] sid,
        input logic [31:0]        ftype,
        input logic [63:0]        ftime,
        input logic [6:0]         idx
    );
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.stream_id  <= sid;
        req_ch.frame_type <= ftype;
        req_ch.frame_time <= ftime;
        req_ch.read_index <= idx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off until every result has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    task automatic mixed_traffic(input int n);
        int          pick;
        int          k;
        logic [31:0] ftype;
        repeat (n) begin
            pick = $urandom_range(99);
            k    = $urandom_range(POOL_SIZE - 1);
            if ($urandom_range(19) == 0) begin
                id_pool[k]   = $urandom;
                type_pool[k] = $urandom;
            end
            ftype = ($urandom_range(3) != 0) ? type_pool[k] : $urandom;
            if (pick < 55) begin
                send_request(REQ_RECORD, id_pool[k], ftype, {$urandom, $urandom},
                             7'($urandom_range(127)));
            end else if (pick < 70) begin
                send_request(REQ_RECORD, $urandom, ftype, {$urandom, $urandom},
                             7'($urandom_range(127)));
            end else if (pick < 90) begin
                send_request(REQ_READ, $urandom, $urandom, {$urandom, $urandom},
                             7'(($urandom_range(3) != 0) ? $urandom_range(23)
                                                         : $urandom_range(127)));
            end else if (pick < 93) begin
                send_request(REQ_UNUSED, $urandom, $urandom, {$urandom, $urandom},
                             7'($urandom_range(127)));
            end else if (pick < 96) begin
                send_request(REQ_CLEAR, $urandom, $urandom, {$urandom, $urandom},
                             7'($urandom_range(127)));
            end else begin
                wait_drained();
                send_request(REQ_RECORD, id_pool[k], ftype, {$urandom, $urandom},
                             7'($urandom_range(127)));
            end
        end
    endtask

    // fill every slot, overflow, poke the halted table, then clear
    task automatic fill_until_full();
        logic [31:0] base;
        int          pick;
        base = $urandom;
        send_request(REQ_CLEAR, $urandom, $urandom, {$urandom, $urandom},
                     7'($urandom_range(127)));
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (n > 0 && $urandom_range(7) == 0)
                send_request(REQ_RECORD, base + $urandom_range(n - 1), $urandom,
                             {$urandom, $urandom}, 7'($urandom_range(127)));
            send_request(REQ_RECORD, base + n, $urandom, {$urandom, $urandom},
                         7'($urandom_range(127)));
        end
        send_request(REQ_RECORD, base - 1, $urandom, {$urandom, $urandom},
                     7'($urandom_range(127)));
        repeat (6) begin
            pick = $urandom_range(3);
            case (pick)
                0: send_request(REQ_RECORD, base + $urandom_range(TABLE_DEPTH - 1),
                                $urandom, {$urandom, $urandom},
                                7'($urandom_range(127)));
                1: send_request(REQ_RECORD, $urandom, $urandom, {$urandom, $urandom},
                                7'($urandom_range(127)));
                2: send_request(REQ_READ, $urandom, $urandom, {$urandom, $urandom},
                                7'($urandom_range(127)));
                default: send_request(REQ_READ, $urandom, $urandom,
                                      {$urandom, $urandom}, 7'd127);
            endcase
        end
        send_request(REQ_CLEAR, $urandom, $urandom, {$urandom, $urandom},
                     7'($urandom_range(127)));
    endtask

    initial begin
        i_rst_n           = 1'b0;
        src_idle_pct      = 22;
        sink_idle_pct     = 68;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_RECORD;
        req_ch.stream_id  = '0;
        req_ch.frame_type = '0;
        req_ch.frame_time = '0;
        req_ch.read_index = '0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            id_pool[k]   = $urandom;
            type_pool[k] = $urandom;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(REQ_READ, 32'sd0, 32'h0, 64'h0, 7'd0);
        send_request(REQ_READ, 32'sd0, 32'h0, 64'h0, 7'd127);
        send_request(REQ_RECORD, 32'h8000_0000, 32'h0, 64'h0, 7'd0);
        send_request(REQ_RECORD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     7'd127);
        send_request(REQ_RECORD, 32'sd0, 32'h4652_4D31, 64'h3FF0_0000_0000_0000, 7'd0);
        send_request(REQ_RECORD, 32'h8000_0000, 32'h0, 64'h4000_0000_0000_0000, 7'd0);
        send_request(REQ_RECORD, 32'h7FFF_FFFF, 32'h0, 64'h4008_0000_0000_0000, 7'd0);
        send_request(REQ_READ, 32'sd0, 32'h0, 64'h0, 7'd0);
        send_request(REQ_READ, 32'sd0, 32'h0, 64'h0, 7'd1);
        send_request(REQ_READ, 32'sd0, 32'h0, 64'h0, 7'd2);
        send_request(REQ_READ, 32'sd0, 32'h0, 64'h0, 7'd3);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     7'd127);
        send_request(REQ_CLEAR, 32'sd0, 32'h0, 64'h0, 7'd0);
        send_request(REQ_READ, 32'sd0, 32'h0, 64'h0, 7'd0);
        send_request(REQ_RECORD, 32'hFFFF_FFFF, 32'h0, 64'h1, 7'd0);
        send_request(REQ_READ, 32'sd0, 32'h0, 64'h0, 7'd0);
        send_request(REQ_RECORD, 32'hFFFF_FFFF, 32'h0, 64'h2, 7'd0);

        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    src_idle_pct  = 22;
                    sink_idle_pct = 68;
                end
                1: begin
                    src_idle_pct  = 68;
                    sink_idle_pct = 22;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            mixed_traffic(40);
            if (phase != 1)
                fill_until_full();
            mixed_traffic((phase == 1) ? 55 : 28);
        end

        wait_drained();
        repeat (DRAIN_HOLD) @(negedge i_clk);
        if (checker_fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
